/* design/gtlc_pkg.sv */
`timescale 1ns / 1ps
// Types and constants shared by the GBK text layout cursor block.
package gtlc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COORD_W    = 16;
	localparam int CURSOR_W   = 17;
	localparam int SIZE_W     = 9;
	localparam int CODE_W     = 8;

	localparam logic [CURSOR_W-1:0] CURSOR_MAX    = 17'h1FFFF;
	localparam logic [CODE_W-1:0]   WIDE_LEAD_MIN = 8'h80;
	localparam logic [CODE_W-1:0]   CR_CODE       = 8'd13;
	localparam logic [CODE_W-1:0]   TERM_CODE     = 8'd0;

	localparam logic [COORD_W-1:0] RST_ORIGIN_X    = 16'd0;
	localparam logic [COORD_W-1:0] RST_ORIGIN_Y    = 16'd0;
	localparam logic [COORD_W-1:0] RST_AREA_WIDTH  = 16'd800;
	localparam logic [COORD_W-1:0] RST_AREA_HEIGHT = 16'd480;
	localparam logic [SIZE_W-1:0]  RST_GLYPH_SIZE  = 9'd24;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_HALF = 2'd1,
		KIND_WIDE = 2'd2
	} draw_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X    = 3'd0,
		REG_ORIGIN_Y    = 3'd1,
		REG_AREA_WIDTH  = 3'd2,
		REG_AREA_HEIGHT = 3'd3,
		REG_GLYPH_SIZE  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] area_width;
		logic [COORD_W-1:0] area_height;
		logic [SIZE_W-1:0]  glyph_size;
	} cfg_t;

	typedef struct packed {
		draw_kind_t         kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [CODE_W-1:0]  first_code;
		logic [CODE_W-1:0]  second_code;
		logic               area_full;
	} draw_t;

endpackage

/* design/gtlc_byte_if.sv */
`timescale 1ns / 1ps
// Input channel carrying one string byte per item.
interface gtlc_byte_if;
	import gtlc_pkg::*;

	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] code_byte;

	modport source (output valid, output code_byte, input ready);
	modport sink (input valid, input code_byte, output ready);
endinterface

/* design/gtlc_draw_if.sv */
`timescale 1ns / 1ps
// Output channel carrying one draw command per item.
interface gtlc_draw_if;
	import gtlc_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         draw_kind;
	logic [COORD_W-1:0] draw_x;
	logic [COORD_W-1:0] draw_y;
	logic [CODE_W-1:0]  first_code;
	logic [CODE_W-1:0]  second_code;
	logic               area_full;

	modport source (output valid, output draw_kind, output draw_x, output draw_y,
		output first_code, output second_code, output area_full, input ready);
	modport sink (input valid, input draw_kind, input draw_x, input draw_y,
		input first_code, input second_code, input area_full, output ready);
endinterface

/* design/gtlc_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
interface gtlc_cfg_if;
	import gtlc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* design/gtlc_cfg_regs.sv */
`timescale 1ns / 1ps
// Configuration register file for the text box and glyph size.
module gtlc_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	gtlc_cfg_if.sink       cfg,
	output gtlc_pkg::cfg_t regs
);
	import gtlc_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.origin_x    <= RST_ORIGIN_X;
			regs_q.origin_y    <= RST_ORIGIN_Y;
			regs_q.area_width  <= RST_AREA_WIDTH;
			regs_q.area_height <= RST_AREA_HEIGHT;
			regs_q.glyph_size  <= RST_GLYPH_SIZE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIGIN_X:    regs_q.origin_x    <= cfg.data;
				REG_ORIGIN_Y:    regs_q.origin_y    <= cfg.data;
				REG_AREA_WIDTH:  regs_q.area_width  <= cfg.data;
				REG_AREA_HEIGHT: regs_q.area_height <= cfg.data;
				REG_GLYPH_SIZE:  regs_q.glyph_size  <= cfg.data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end
endmodule

/* design/gtlc_cursor.sv */
`timescale 1ns / 1ps
// Cursor state and the combinational placement, wrap and stop logic for one byte.
module gtlc_cursor (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gtlc_pkg::cfg_t              regs,
	input  logic                        step,
	input  logic [gtlc_pkg::CODE_W-1:0] code_byte,
	output gtlc_pkg::draw_t             result
);
	import gtlc_pkg::*;

	logic [CURSOR_W-1:0] cursor_x_q, cursor_y_q;
	logic [CODE_W-1:0]   lead_byte_q;
	logic                in_wide_q, skip_q, stopped_q;

	logic [CURSOR_W-1:0] cursor_x_d, cursor_y_d;
	logic [CODE_W-1:0]   lead_byte_d;
	logic                in_wide_d, skip_d, stopped_d;

	logic                is_term, is_lead, is_cr;
	logic                wide_path, half_path;
	logic [SIZE_W-1:0]   half, adv;
	logic [17:0]         x_need, right_edge, bottom_edge, y_need;
	logic                wrap, stop_hit;
	logic [CURSOR_W-1:0] x_wrap, x_base;
	logic [17:0]         y_wrap, y_fin, x_fin;

	function automatic logic [CURSOR_W-1:0] sat17(input logic [17:0] v);
		return v[17] ? CURSOR_MAX : v[CURSOR_W-1:0];
	endfunction

	always_comb begin
		is_term   = (code_byte == TERM_CODE);
		is_lead   = (code_byte > WIDE_LEAD_MIN);
		is_cr     = (code_byte == CR_CODE);
		wide_path = !is_term && !stopped_q && !skip_q && in_wide_q;
		half_path = !is_term && !stopped_q && !skip_q && !in_wide_q && !is_lead;
		half      = {1'b0, regs.glyph_size[SIZE_W-1:1]};
		adv       = wide_path ? regs.glyph_size : half;

		x_need      = {1'b0, cursor_x_q} + {9'd0, adv};
		right_edge  = {2'b00, regs.origin_x} + {2'b00, regs.area_width};
		wrap        = (x_need > right_edge);
		x_wrap      = wrap ? {1'b0, regs.origin_x} : cursor_x_q;
		y_wrap      = {1'b0, cursor_y_q} + (wrap ? {9'd0, regs.glyph_size} : 18'd0);
		y_need      = y_wrap + {9'd0, regs.glyph_size};
		bottom_edge = {2'b00, regs.origin_y} + {2'b00, regs.area_height};
		stop_hit    = (y_need > bottom_edge);

		x_base = (half_path && is_cr) ? {1'b0, regs.origin_x} : x_wrap;
		y_fin  = (half_path && is_cr) ? y_need : y_wrap;
		x_fin  = {1'b0, x_base} + {9'd0, adv};
	end

	always_comb begin
		cursor_x_d  = cursor_x_q;
		cursor_y_d  = cursor_y_q;
		lead_byte_d = lead_byte_q;
		in_wide_d   = in_wide_q;
		skip_d      = skip_q;
		stopped_d   = stopped_q;
		if (is_term) begin
			cursor_x_d  = {1'b0, regs.origin_x};
			cursor_y_d  = {1'b0, regs.origin_y};
			lead_byte_d = '0;
			in_wide_d   = 1'b0;
			skip_d      = 1'b0;
			stopped_d   = 1'b0;
		end else if (stopped_q) begin
		end else if (skip_q) begin
			skip_d = 1'b0;
		end else if (in_wide_q) begin
			in_wide_d = 1'b0;
			if (stop_hit) begin
				stopped_d = 1'b1;
			end else begin
				cursor_x_d = sat17(x_fin);
				cursor_y_d = sat17(y_fin);
			end
		end else if (is_lead) begin
			lead_byte_d = code_byte;
			in_wide_d   = 1'b1;
		end else if (stop_hit) begin
			stopped_d = 1'b1;
		end else begin
			cursor_x_d = sat17(x_fin);
			cursor_y_d = sat17(y_fin);
			skip_d     = is_cr;
		end
	end

	always_comb begin
		result             = '0;
		result.kind        = KIND_NONE;
		result.area_full   = stopped_d;
		if (!stop_hit && wide_path) begin
			result.kind        = KIND_WIDE;
			result.x           = x_wrap[COORD_W-1:0];
			result.y           = y_wrap[COORD_W-1:0];
			result.first_code  = lead_byte_q;
			result.second_code = code_byte;
		end else if (!stop_hit && half_path && !is_cr) begin
			result.kind       = KIND_HALF;
			result.x          = x_wrap[COORD_W-1:0];
			result.y          = y_wrap[COORD_W-1:0];
			result.first_code = code_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q  <= {1'b0, RST_ORIGIN_X};
			cursor_y_q  <= {1'b0, RST_ORIGIN_Y};
			lead_byte_q <= '0;
			in_wide_q   <= 1'b0;
			skip_q      <= 1'b0;
			stopped_q   <= 1'b0;
		end else if (step) begin
			cursor_x_q  <= cursor_x_d;
			cursor_y_q  <= cursor_y_d;
			lead_byte_q <= lead_byte_d;
			in_wide_q   <= in_wide_d;
			skip_q      <= skip_d;
			stopped_q   <= stopped_d;
		end
	end

	a_term_rearms: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_term |=> cursor_x_q == {1'b0, $past(regs.origin_x)}
			&& !stopped_q && !in_wide_q && !skip_q)
		else $error("terminator did not re-arm the cursor");

	a_skip_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(skip_q && in_wide_q))
		else $error("swallow and wide glyph pending together");

	a_stopped_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && stopped_q && !is_term |=> stopped_q && $stable(cursor_x_q)
			&& $stable(cursor_y_q))
		else $error("cursor moved while stopped");
endmodule

/* design/gbk_text_layout_cursor_core.sv */
`timescale 1ns / 1ps
// Top level of the GBK text layout cursor: input register, cursor logic, result register.
//
// Takes one string byte per cycle while the result register is not stalled, and returns
// one draw command for every byte, in order. A byte is held in the input register, and the
// cursor update for it settles in the same cycle it moves into the result register, where
// its command appears; the cursor update loop is combinational. A stalled result register
// holds its command while the input register still takes one more byte. Configuration
// writes are taken in any cycle and should be made only while no byte is in flight; origin
// changes move the cursor at the next terminator byte.
module gbk_text_layout_cursor_core (
	input  logic        clk,
	input  logic        arst_n,
	gtlc_byte_if.sink   code,
	gtlc_draw_if.source draw,
	gtlc_cfg_if.sink    cfg
);
	import gtlc_pkg::*;

	cfg_t              regs;
	logic              code_valid_s1;
	logic [CODE_W-1:0] code_byte_s1;
	logic              advance;
	draw_t             result;
	logic              draw_valid_q;
	draw_t             draw_q;

	assign advance    = code_valid_s1 && (!draw_valid_q || draw.ready);
	assign code.ready = !code_valid_s1 || advance;

	gtlc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	gtlc_cursor u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.regs      (regs),
		.step      (advance),
		.code_byte (code_byte_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_valid_s1 <= 1'b0;
		end else if (code.ready) begin
			code_valid_s1 <= code.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code.valid && code.ready) begin
			code_byte_s1 <= code.code_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			draw_valid_q <= 1'b0;
		end else if (advance) begin
			draw_valid_q <= 1'b1;
		end else if (draw.ready) begin
			draw_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			draw_q <= result;
		end
	end

	assign draw.valid       = draw_valid_q;
	assign draw.draw_kind   = draw_q.kind;
	assign draw.draw_x      = draw_q.x;
	assign draw.draw_y      = draw_q.y;
	assign draw.first_code  = draw_q.first_code;
	assign draw.second_code = draw_q.second_code;
	assign draw.area_full   = draw_q.area_full;

	a_full_draws_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid_q && draw_q.area_full |-> draw_q.kind == KIND_NONE)
		else $error("draw command issued while the box is full");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid_q && draw_q.kind == KIND_NONE |-> draw_q.x == '0
			&& draw_q.y == '0 && draw_q.first_code == '0 && draw_q.second_code == '0)
		else $error("empty command carries payload");

	a_half_no_trail: assert property (@(posedge clk) disable iff (!arst_n)
		draw_valid_q && draw_q.kind != KIND_WIDE |-> draw_q.second_code == '0)
		else $error("trail byte on a non-wide command");

	a_stall_keeps_input: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid_s1 && draw_valid_q && !draw.ready |=> code_valid_s1
			&& $stable(code_byte_s1))
		else $error("input register lost its item under stall");
endmodule

/* sim/gbk_text_layout_cursor_checker.sv */
`timescale 1ns / 1ps
// Checker for the GBK text layout cursor: predicts each draw item and compares it on arrival.
module gbk_text_layout_cursor_checker (
	input  logic  clk,
	input  logic  arst_n,
	gtlc_byte_if  code,
	gtlc_draw_if  draw,
	gtlc_cfg_if   cfg,
	output int    fail_count,
	output int    pending
);
	import gtlc_pkg::*;

	cfg_t                box;
	logic [CURSOR_W-1:0] cur_x;
	logic [CURSOR_W-1:0] cur_y;
	logic [CODE_W-1:0]   lead;
	logic                in_wide;
	logic                skip_byte;
	logic                stopped;
	draw_t               expected_draws[$];
	int                  faults = 0;

	assign fail_count = faults;

	task automatic report_fault(input string msg);
		$display("%0t ns: %s", $time, msg);
		faults++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_fault($sformatf("draw %s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	function automatic logic [CURSOR_W-1:0] clamp_cursor(input int v);
		if (v < 0)
			return '0;
		if (v > int'(CURSOR_MAX))
			return CURSOR_MAX;
		return v[CURSOR_W-1:0];
	endfunction

	task automatic rearm_cursor();
		cur_x = {1'b0, box.origin_x};
		cur_y = {1'b0, box.origin_y};
		lead = '0;
		in_wide = 1'b0;
		skip_byte = 1'b0;
		stopped = 1'b0;
	endtask

	task automatic wrap_line(inout int x, inout int y, input int advance, output bit full);
		if (x > int'(box.origin_x) + int'(box.area_width) - advance) begin
			y += int'(box.glyph_size);
			x = int'(box.origin_x);
		end
		full = y > int'(box.origin_y) + int'(box.area_height) - int'(box.glyph_size);
	endtask

	task automatic lay_out_byte(input logic [CODE_W-1:0] b, output draw_t cmd);
		int x;
		int y;
		int size;
		int half;
		bit full;
		cmd = '0;
		cmd.kind = KIND_NONE;
		size = int'(box.glyph_size);
		half = size / 2;
		x = int'(cur_x);
		y = int'(cur_y);
		if (b == TERM_CODE) begin
			rearm_cursor();
		end else if (stopped) begin
			// hold until the terminator
		end else if (skip_byte) begin
			skip_byte = 1'b0;
		end else if (in_wide) begin
			in_wide = 1'b0;
			wrap_line(x, y, size, full);
			if (full) begin
				stopped = 1'b1;
			end else begin
				cmd.kind = KIND_WIDE;
				cmd.x = x[COORD_W-1:0];
				cmd.y = y[COORD_W-1:0];
				cmd.first_code = lead;
				cmd.second_code = b;
				cur_x = clamp_cursor(x + size);
				cur_y = clamp_cursor(y);
			end
		end else if (b > WIDE_LEAD_MIN) begin
			lead = b;
			in_wide = 1'b1;
		end else begin
			wrap_line(x, y, half, full);
			if (full) begin
				stopped = 1'b1;
			end else begin
				if (b == CR_CODE) begin
					y += size;
					x = int'(box.origin_x);
					skip_byte = 1'b1;
				end else begin
					cmd.kind = KIND_HALF;
					cmd.x = x[COORD_W-1:0];
					cmd.y = y[COORD_W-1:0];
					cmd.first_code = b;
				end
				cur_x = clamp_cursor(x + half);
				cur_y = clamp_cursor(y);
			end
		end
		cmd.area_full = stopped;
	endtask

	always @(posedge clk or negedge arst_n) begin
		draw_t cmd;
		if (!arst_n) begin
			box.origin_x = RST_ORIGIN_X;
			box.origin_y = RST_ORIGIN_Y;
			box.area_width = RST_AREA_WIDTH;
			box.area_height = RST_AREA_HEIGHT;
			box.glyph_size = RST_GLYPH_SIZE;
			rearm_cursor();
			expected_draws.delete();
			pending <= 0;
		end else begin
			if (draw.valid && draw.ready) begin
				if (expected_draws.size() == 0) begin
					report_fault($sformatf("draw item kind %0d x 0x%0h y 0x%0h with none expected",
						draw.draw_kind, draw.draw_x, draw.draw_y));
				end else begin
					cmd = expected_draws.pop_front();
					check_field("kind", 16'(draw.draw_kind), 16'(cmd.kind));
					check_field("x", draw.draw_x, cmd.x);
					check_field("y", draw.draw_y, cmd.y);
					check_field("first_code", 16'(draw.first_code), 16'(cmd.first_code));
					check_field("second_code", 16'(draw.second_code), 16'(cmd.second_code));
					check_field("area_full", 16'(draw.area_full), 16'(cmd.area_full));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ORIGIN_X:    box.origin_x = cfg.data;
					REG_ORIGIN_Y:    box.origin_y = cfg.data;
					REG_AREA_WIDTH:  box.area_width = cfg.data;
					REG_AREA_HEIGHT: box.area_height = cfg.data;
					REG_GLYPH_SIZE:  box.glyph_size = cfg.data[SIZE_W-1:0];
					default: ;
				endcase
			end
			if (code.valid && code.ready) begin
				lay_out_byte(code.code_byte, cmd);
				expected_draws.push_back(cmd);
			end
			pending <= expected_draws.size();
		end
	end

endmodule

/* sim/gbk_text_layout_cursor_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the GBK text layout cursor: clock, reset, byte strings, box settings, verdict.
module gbk_text_layout_cursor_core_tb;
	import gtlc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 180;

	logic clk;
	logic arst_n;
	bit   gaps_on;
	int   fail_count;
	int   pending;
	int   items_sent;

	gtlc_byte_if code_ch();
	gtlc_draw_if draw_ch();
	gtlc_cfg_if  cfg_ch();

	gbk_text_layout_cursor_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_ch),
		.draw   (draw_ch),
		.cfg    (cfg_ch)
	);

	gbk_text_layout_cursor_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.code       (code_ch),
		.draw       (draw_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("gbk_text_layout_cursor_core verification failed");
		$finish;
	end

	initial begin
		draw_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (gaps_on && $urandom_range(0, 3) == 0) begin
				draw_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
			draw_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [CODE_W-1:0] b);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			code_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		code_ch.valid <= 1'b1;
		code_ch.code_byte <= b;
		do @(posedge clk); while (!code_ch.ready);
		items_sent++;
	endtask

	task automatic drain_results();
		code_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic load_box(input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
			input logic [COORD_W-1:0] w, input logic [COORD_W-1:0] h,
			input logic [SIZE_W-1:0] size);
		logic [CFG_DATA_W-SIZE_W-1:0] junk;
		junk = 7'($urandom_range(0, 127));
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_AREA_WIDTH, w);
		write_reg(REG_AREA_HEIGHT, h);
		write_reg(REG_GLYPH_SIZE, {junk, size});
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_text(input int len, input bit noisy);
		int pick;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (noisy && pick < 20) begin
				send_byte(8'($urandom_range(0, 255)));
			end else if (pick < 50) begin
				send_byte(8'($urandom_range(8'h20, 8'h7E)));
			end else if (pick < 58) begin
				send_byte(CR_CODE);
				send_byte(8'($urandom_range(1, 255)));
			end else if (pick < 66) begin
				send_byte(8'($urandom_range(1, WIDE_LEAD_MIN)));
			end else begin
				send_byte(8'($urandom_range(WIDE_LEAD_MIN + 1, 8'hFF)));
				send_byte(noisy ? 8'($urandom_range(1, 255)) : 8'($urandom_range(8'h40, 8'hFE)));
			end
		end
		if (!noisy || $urandom_range(0, 1) == 1)
			send_byte(TERM_CODE);
	endtask

	initial begin
		int  phase_start;
		bit  paused;
		arst_n = 1'b0;
		gaps_on = 1'b1;
		items_sent = 0;
		paused = 1'b0;
		code_ch.valid <= 1'b0;
		code_ch.code_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_byte(8'h41); send_byte(8'h01); send_byte(8'h80); send_byte(8'h7F);
		send_byte(8'h81); send_byte(8'h40);
		send_byte(8'hFF); send_byte(8'hFF);
		send_byte(CR_CODE); send_byte(8'h42); send_byte(8'h43);
		send_byte(8'hB0); send_byte(TERM_CODE);
		send_byte(CR_CODE); send_byte(TERM_CODE);
		send_byte(8'hA1); send_byte(CR_CODE);
		drain_results();
		load_box(16'd0, 16'd0, 16'd40, 16'd30, 9'd24);
		send_byte(8'h61); send_byte(8'h62); send_byte(8'h63); send_byte(8'h64);
		send_byte(8'h65); send_byte(8'hC1); send_byte(TERM_CODE);
		send_byte(8'h71);
		drain_results();
		load_box(16'd5, 16'd7, RST_AREA_WIDTH, RST_AREA_HEIGHT, RST_GLYPH_SIZE);
		send_byte(8'h72); send_byte(TERM_CODE); send_byte(8'h73);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: load_box(RST_ORIGIN_X, RST_ORIGIN_Y, RST_AREA_WIDTH, RST_AREA_HEIGHT,
					RST_GLYPH_SIZE);
				1: load_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9'd256);
				2: load_box(16'd0, 16'd0, 16'd0, 16'd0, 9'd1);
				3: load_box(16'd0, 16'd0, 16'd100, 16'd60, 9'd8);
				4: begin
					write_reg(REG_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
					load_box(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
						16'd333, 16'd97, 9'd0);
				end
				5: load_box(16'd10, 16'd20, 16'd2000, 16'd3000, 9'h1FF);
				default: load_box(16'($urandom_range(0, 16'hFFFF)),
					16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 640)),
					16'($urandom_range(0, 320)), 9'($urandom_range(1, 64)));
			endcase
			if (phase == PHASES - 1)
				gaps_on <= 1'b0;
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if (phase == 3 && !paused && items_sent - phase_start > PHASE_ITEMS / 2) begin
					drain_results();
					paused = 1'b1;
				end
				if ($urandom_range(0, 9) == 0)
					send_text($urandom_range(60, 200), $urandom_range(0, 4) == 0);
				else
					send_text($urandom_range(1, 30), $urandom_range(0, 4) == 0);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("gbk_text_layout_cursor_core verification clean");
		end else begin
			$display("gbk_text_layout_cursor_core verification failed");
		end
		$finish;
	end

endmodule
